@@ rtl/kpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kpc_pkg;

    localparam int VALUE_BITS    = 48;
    localparam int FRACTION_BITS = 16;
    localparam int CMD_BITS      = 4;
    localparam int DIGIT_BITS    = 4;
    localparam int DISP_BITS     = 48;
    localparam int STATUS_BITS   = 2;

    localparam int NUM_BITS  = VALUE_BITS + FRACTION_BITS;
    localparam int PROD_BITS = 2 * VALUE_BITS;
    localparam int MAG_BITS  = (PROD_BITS - FRACTION_BITS > NUM_BITS) ?
                               (PROD_BITS - FRACTION_BITS) : NUM_BITS;
    localparam int CNT_BITS  = $clog2(NUM_BITS);
    localparam int WIDE_BITS = (VALUE_BITS > DISP_BITS) ? VALUE_BITS : DISP_BITS;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic signed [VALUE_BITS:0]   t_sum;
    typedef logic [VALUE_BITS-1:0]        t_mag;
    typedef logic [NUM_BITS-1:0]          t_num;
    typedef logic [PROD_BITS-1:0]         t_prod;
    typedef logic [MAG_BITS-1:0]          t_magw;
    typedef logic [CNT_BITS-1:0]          t_cnt;

    localparam t_value VALUE_MAX  = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam t_value VALUE_MIN  = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam t_value MAX_DIV10  = VALUE_MAX / 10;
    localparam t_value MIN_DIV10  = VALUE_MIN / 10;
    localparam t_mag   DIVISOR_TEN = t_mag'(10);
    localparam t_mag   DIGIT_MAX   = t_mag'(9);
    localparam t_mag   WHOLE_MASK  = ~((t_mag'(1) << FRACTION_BITS) - t_mag'(1));
    localparam t_magw  MAG_POS_LIM = t_magw'(t_mag'(VALUE_MAX));
    localparam t_magw  MAG_NEG_LIM = MAG_POS_LIM + t_magw'(1);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_DIGIT   = 4'd0,
        CMD_NEGATE  = 4'd1,
        CMD_DELETE  = 4'd2,
        CMD_ADD     = 4'd3,
        CMD_SUB     = 4'd4,
        CMD_MUL     = 4'd5,
        CMD_DIV     = 4'd6,
        CMD_EQUALS  = 4'd7,
        CMD_CLEAR   = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK   = 2'd0,
        STAT_DIVZ = 2'd1,
        STAT_OVF  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_KEEP,
        K_NEG,
        K_DEL,
        K_ZERO
    } t_kind;

    typedef enum logic [1:0] {
        WB_NONE,
        WB_OPND,
        WB_CHAIN,
        WB_LAST
    } t_wb;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIGIT,
        S_ALU,
        S_MUL,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_status status;
        t_value  value;
    } t_res;

    function automatic t_res sat_sum(input t_sum s);
        t_res r;
        r.status = STAT_OK;
        r.value  = s[VALUE_BITS-1:0];
        if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
            r.status = STAT_OVF;
            r.value  = s[VALUE_BITS] ? VALUE_MIN : VALUE_MAX;
        end
        return r;
    endfunction

    function automatic t_res sat_mag(input t_magw m, input logic neg);
        t_res r;
        r.status = STAT_OK;
        if (neg) begin
            if (m > MAG_NEG_LIM) begin
                r.status = STAT_OVF;
                r.value  = VALUE_MIN;
            end else begin
                r.value = t_value'(0) - t_value'(m[VALUE_BITS-1:0]);
            end
        end else begin
            if (m > MAG_POS_LIM) begin
                r.status = STAT_OVF;
                r.value  = VALUE_MAX;
            end else begin
                r.value = t_value'(m[VALUE_BITS-1:0]);
            end
        end
        return r;
    endfunction

    function automatic t_mag magnitude(input t_value v);
        return v[VALUE_BITS-1] ? (t_mag'(0) - t_mag'(v)) : t_mag'(v);
    endfunction

    function automatic logic [DISP_BITS-1:0] to_disp(input t_value v);
        logic signed [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        return w[DISP_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/kpc_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface kpc_key_if;
    import kpc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_BITS-1:0]   command;
    logic [DIGIT_BITS-1:0] digit;

    modport source (output valid, output command, output digit, input ready);
    modport sink (input valid, input command, input digit, output ready);
endinterface

interface kpc_disp_if;
    import kpc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [DISP_BITS-1:0]   display_value;
    logic [STATUS_BITS-1:0]        status;

    modport source (output valid, output display_value, output status, input ready);
    modport sink (input valid, input display_value, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/keypad_four_function_calculator.sv @@
// Add, subtract, negate, clear, equals with no pending operator and a division by zero pass ALU
// and emit; a digit passes the digit state first (a saturating one goes from there to emit). Multiply
// also passes the multiply state (one multiplier bit a cycle), divide and delete the divide state
// (one of 64 quotient bits a cycle), then the sign state. Equals and a chaining operator take the
// path of the pending operation. One key is in work at a time, and an unread result holds the next one back.
// Synchronous active-low reset clears operands, flags, operator and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module keypad_four_function_calculator (
    input  wire        i_clk,
    input  wire        i_rst_n,
    kpc_key_if.sink    i_key,
    kpc_disp_if.source o_disp
);
    import kpc_pkg::*;

    t_state  r_state, n_state;
    t_value  r_first, n_first;
    t_value  r_second, n_second;
    t_value  r_last, n_last;
    t_op     r_op, n_op;
    logic    r_es, n_es;
    logic    r_ae, n_ae;
    logic    r_out_valid, n_out_valid;

    t_value  r_a, n_a;
    t_value  r_b, n_b;
    t_mag    r_dig, n_dig;
    t_kind   r_kind, n_kind;
    t_wb     r_wb, n_wb;
    logic    r_tgt2, n_tgt2;
    logic    r_neg, n_neg;
    t_prod   r_prod, n_prod;
    t_mag    r_mcand, n_mcand;
    t_num    r_num, n_num;
    t_mag    r_rem, n_rem;
    t_mag    r_dvs, n_dvs;
    t_cnt    r_cnt, n_cnt;
    t_res    r_res, n_res;
    logic [DISP_BITS-1:0]   r_out_value, n_out_value;
    logic [STATUS_BITS-1:0] r_out_status, n_out_status;

    logic    w_in_ready;
    logic    w_in_acc;
    logic    w_emit;
    logic    w_dig_ovp;
    logic    w_dig_ovn;
    t_kind   w_op_kind;
    t_op     w_new_op;
    t_value  w_opnd;
    t_mag    w_mag_a;
    t_mag    w_mag_b;
    t_mag    w_rem2;
    logic [VALUE_BITS:0] w_diff;
    logic [VALUE_BITS:0] w_psum;
    t_magw   w_mag_out;

    assign w_in_acc  = i_key.valid && w_in_ready;
    assign w_dig_ovp = r_a > MAX_DIV10;
    assign w_dig_ovn = r_a < MIN_DIV10;
    assign w_opnd    = r_ae ? t_value'(0) : (r_es ? r_second : r_first);
    assign w_mag_a   = magnitude(r_a);
    assign w_mag_b   = magnitude(r_b);
    assign w_rem2    = {r_rem[VALUE_BITS-2:0], r_num[NUM_BITS-1]};
    assign w_diff    = {1'b0, w_rem2} - {1'b0, r_dvs};
    assign w_psum    = r_prod[0] ? ({1'b0, r_prod[PROD_BITS-1:VALUE_BITS]} + {1'b0, r_mcand})
                                 : {1'b0, r_prod[PROD_BITS-1:VALUE_BITS]};

    always_comb begin
        case (r_op)
            OP_ADD:  w_op_kind = K_ADD;
            OP_SUB:  w_op_kind = K_SUB;
            OP_MUL:  w_op_kind = K_MUL;
            OP_DIV:  w_op_kind = K_DIV;
            default: w_op_kind = K_KEEP;
        endcase
    end

    always_comb begin
        case (i_key.command)
            CMD_ADD: w_new_op = OP_ADD;
            CMD_SUB: w_new_op = OP_SUB;
            CMD_MUL: w_new_op = OP_MUL;
            CMD_DIV: w_new_op = OP_DIV;
            default: w_new_op = OP_NONE;
        endcase
    end

    always_comb begin
        case (r_kind)
            K_MUL:   w_mag_out = t_magw'(r_prod >> FRACTION_BITS);
            K_DEL:   w_mag_out = t_magw'(r_num[VALUE_BITS-1:0] & WHOLE_MASK);
            default: w_mag_out = t_magw'(r_num);
        endcase
    end

    always_comb begin
        w_in_ready = (r_state == S_IDLE);
        w_emit     = (r_state == S_EMIT) && (!r_out_valid || o_disp.ready);
    end

    assign i_key.ready          = w_in_ready;
    assign o_disp.valid         = r_out_valid;
    assign o_disp.display_value = r_out_value;
    assign o_disp.status        = r_out_status;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_key.command)
                        CMD_DIGIT:                               n_state = S_DIGIT;
                        CMD_NEGATE, CMD_DELETE, CMD_EQUALS, CMD_CLEAR: n_state = S_ALU;
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:      n_state = r_es ? S_ALU : S_IDLE;
                        default:                                 n_state = S_IDLE;
                    endcase
                end
            end
            S_DIGIT: begin
                n_state = (w_dig_ovp || w_dig_ovn) ? S_EMIT : S_ALU;
            end
            S_ALU: begin
                case (r_kind)
                    K_MUL:   n_state = S_MUL;
                    K_DIV:   n_state = (r_b == t_value'(0)) ? S_EMIT : S_DIV;
                    K_DEL:   n_state = S_DIV;
                    default: n_state = S_EMIT;
                endcase
            end
            S_MUL, S_DIV: begin
                if (r_cnt == t_cnt'(0)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_first      = r_first;
        n_second     = r_second;
        n_last       = r_last;
        n_op         = r_op;
        n_es         = r_es;
        n_ae         = r_ae;
        n_a          = r_a;
        n_b          = r_b;
        n_dig        = r_dig;
        n_kind       = r_kind;
        n_wb         = r_wb;
        n_tgt2       = r_tgt2;
        n_neg        = r_neg;
        n_prod       = r_prod;
        n_mcand      = r_mcand;
        n_num        = r_num;
        n_rem        = r_rem;
        n_dvs        = r_dvs;
        n_cnt        = r_cnt;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !o_disp.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_key.command)
                        CMD_DIGIT, CMD_NEGATE, CMD_DELETE: begin
                            if (r_ae) begin
                                n_first  = t_value'(0);
                                n_second = t_value'(0);
                                n_last   = t_value'(0);
                                n_op     = OP_NONE;
                                n_es     = 1'b0;
                                n_ae     = 1'b0;
                            end
                            n_tgt2 = !r_ae && r_es;
                            n_a    = w_opnd;
                            n_wb   = WB_OPND;
                            n_dig  = (t_mag'(i_key.digit) > DIGIT_MAX) ? DIGIT_MAX
                                                                       : t_mag'(i_key.digit);
                            n_kind = (i_key.command == CMD_NEGATE) ? K_NEG : K_DEL;
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                            n_ae = 1'b0;
                            n_op = w_new_op;
                            if (r_es) begin
                                n_a      = r_first;
                                n_b      = r_second;
                                n_kind   = w_op_kind;
                                n_second = t_value'(0);
                                n_wb     = WB_CHAIN;
                            end else begin
                                n_es = 1'b1;
                            end
                        end
                        CMD_EQUALS: begin
                            n_a = r_ae ? r_last : r_first;
                            if (r_ae) begin
                                n_first = r_last;
                            end
                            n_b    = r_second;
                            n_kind = w_op_kind;
                            n_ae   = 1'b1;
                            n_wb   = WB_LAST;
                        end
                        CMD_CLEAR: begin
                            n_first  = t_value'(0);
                            n_second = t_value'(0);
                            n_last   = t_value'(0);
                            n_op     = OP_NONE;
                            n_es     = 1'b0;
                            n_ae     = 1'b0;
                            n_kind   = K_ZERO;
                            n_wb     = WB_NONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIGIT: begin
                if (w_dig_ovp) begin
                    n_res.value  = VALUE_MAX;
                    n_res.status = STAT_OVF;
                end else if (w_dig_ovn) begin
                    n_res.value  = VALUE_MIN;
                    n_res.status = STAT_OVF;
                end else begin
                    n_a    = (r_a <<< 3) + (r_a <<< 1);
                    n_b    = t_value'(r_dig << FRACTION_BITS);
                    n_kind = K_ADD;
                end
            end
            S_ALU: begin
                case (r_kind)
                    K_ADD: n_res = sat_sum(t_sum'(r_a) + t_sum'(r_b));
                    K_SUB: n_res = sat_sum(t_sum'(r_a) - t_sum'(r_b));
                    K_NEG: begin
                        n_res.status = (r_a == VALUE_MIN) ? STAT_OVF : STAT_OK;
                        n_res.value  = (r_a == VALUE_MIN) ? VALUE_MAX : (t_value'(0) - r_a);
                    end
                    K_KEEP: begin
                        n_res.status = STAT_OK;
                        n_res.value  = r_last;
                    end
                    K_ZERO: begin
                        n_res.status = STAT_OK;
                        n_res.value  = t_value'(0);
                    end
                    K_MUL: begin
                        n_mcand = w_mag_a;
                        n_prod  = t_prod'(w_mag_b);
                        n_neg   = r_a[VALUE_BITS-1] ^ r_b[VALUE_BITS-1];
                        n_cnt   = t_cnt'(VALUE_BITS - 1);
                    end
                    K_DIV: begin
                        if (r_b == t_value'(0)) begin
                            n_res.status = STAT_DIVZ;
                            n_res.value  = r_a[VALUE_BITS-1] ? VALUE_MIN : VALUE_MAX;
                        end else begin
                            n_num = t_num'(w_mag_a) << FRACTION_BITS;
                            n_dvs = w_mag_b;
                            n_rem = t_mag'(0);
                            n_neg = r_a[VALUE_BITS-1] ^ r_b[VALUE_BITS-1];
                            n_cnt = t_cnt'(NUM_BITS - 1);
                        end
                    end
                    K_DEL: begin
                        n_num = t_num'(w_mag_a);
                        n_dvs = DIVISOR_TEN;
                        n_rem = t_mag'(0);
                        n_neg = r_a[VALUE_BITS-1];
                        n_cnt = t_cnt'(NUM_BITS - 1);
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL: begin
                n_prod = {w_psum, r_prod[VALUE_BITS-1:1]};
                n_cnt  = r_cnt - t_cnt'(1);
            end
            S_DIV: begin
                n_rem = w_diff[VALUE_BITS] ? w_rem2 : w_diff[VALUE_BITS-1:0];
                n_num = {r_num[NUM_BITS-2:0], !w_diff[VALUE_BITS]};
                n_cnt = r_cnt - t_cnt'(1);
            end
            S_SIGN: begin
                n_res = sat_mag(w_mag_out, r_neg);
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = to_disp(r_res.value);
                    n_out_status = r_res.status;
                    case (r_wb)
                        WB_OPND: begin
                            if (r_tgt2) begin
                                n_second = r_res.value;
                            end else begin
                                n_first = r_res.value;
                            end
                        end
                        WB_CHAIN: begin
                            n_last  = r_res.value;
                            n_first = r_res.value;
                        end
                        WB_LAST: n_last = r_res.value;
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= t_value'(0);
            r_second    <= t_value'(0);
            r_last      <= t_value'(0);
            r_op        <= OP_NONE;
            r_es        <= 1'b0;
            r_ae        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_second    <= n_second;
            r_last      <= n_last;
            r_op        <= n_op;
            r_es        <= n_es;
            r_ae        <= n_ae;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a          <= n_a;
        r_b          <= n_b;
        r_dig        <= n_dig;
        r_kind       <= n_kind;
        r_wb         <= n_wb;
        r_tgt2       <= n_tgt2;
        r_neg        <= n_neg;
        r_prod       <= n_prod;
        r_mcand      <= n_mcand;
        r_num        <= n_num;
        r_rem        <= n_rem;
        r_dvs        <= n_dvs;
        r_cnt        <= n_cnt;
        r_res        <= n_res;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

endmodule

`default_nettype wire
